// ----- rtl/mbh_pkg.sv -----
// shared types and constants of the murmur2 bucket hash block
package mbh_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned NBYTES_W   = 3;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned DIV_STEPS  = WORD_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [WORD_W-1:0] MIX_MUL = 32'h5bd1e995;
    localparam int unsigned WORD_SHIFT    = 24;
    localparam int unsigned FIN_SHIFT_A   = 13;
    localparam int unsigned FIN_SHIFT_B   = 15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 8'd1;

    // datapath multiply operations
    typedef logic [2:0] t_op;
    localparam t_op OP_NONE  = 3'd0;
    localparam t_op OP_KMUL1 = 3'd1;
    localparam t_op OP_KMUL2 = 3'd2;
    localparam t_op OP_HMUL  = 3'd3;
    localparam t_op OP_TAIL  = 3'd4;
    localparam t_op OP_FIN   = 3'd5;

    typedef struct packed {
        logic accept;
        t_op  op;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic tail;
        logic last;
    } t_dp_sts;

endpackage

// ----- rtl/mbh_if.sv -----
// handshake channel interfaces: key words, bucket results, configuration writes
interface mbh_key_if
    import mbh_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   key_word;
    logic [NBYTES_W-1:0] bytes_valid;
    logic                first_word;
    logic                last_word;
    logic [WORD_W-1:0]   total_length;

    modport source (output valid, key_word, bytes_valid, first_word, last_word,
                    total_length, input ready);
    modport sink   (input valid, key_word, bytes_valid, first_word, last_word,
                    total_length, output ready);
endinterface

interface mbh_bucket_if
    import mbh_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] bucket_index;

    modport source (output valid, bucket_index, input ready);
    modport sink   (input valid, bucket_index, output ready);
endinterface

interface mbh_cfg_if
    import mbh_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/mbh_dp.sv -----
// datapath: config registers, running hash, shared multiplier, serial modulo
module mbh_dp
    import mbh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [WORD_W-1:0]    i_key_word,
    input  logic [NBYTES_W-1:0]  i_bytes_valid,
    input  logic                 i_first_word,
    input  logic                 i_last_word,
    input  logic [WORD_W-1:0]    i_total_length,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    output logic [WORD_W-1:0]    o_bucket_index
);

    logic [WORD_W-1:0]   r_seed;
    logic [WORD_W-1:0]   r_tsize;
    logic [WORD_W-1:0]   r_hash;
    logic [WORD_W-1:0]   r_word;
    logic [NBYTES_W-1:0] r_nbytes;
    logic                r_last;
    logic [WORD_W-1:0]   r_fin;
    logic [WORD_W-1:0]   r_quo;
    logic [WORD_W-1:0]   r_rem;
    logic [WORD_W-1:0]   r_bucket;

    logic [WORD_W-1:0]   w_mask;
    logic [WORD_W-1:0]   w_mul_a;
    logic [WORD_W-1:0]   w_prod;
    logic [WORD_W:0]     w_trial;
    logic                w_ge;
    logic [WORD_W-1:0]   n_rem;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= '0;
            r_tsize <= WORD_W'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_HASH_SEED) begin
                r_seed <= i_cfg_data;
            end
            if (i_cfg_index == REG_TABLE_SIZE) begin
                r_tsize <= i_cfg_data;
            end
        end
    end

    assign o_sts.full = (r_nbytes >= NBYTES_W'(4));
    assign o_sts.tail = (r_nbytes != '0) && (r_nbytes < NBYTES_W'(4));
    assign o_sts.last = r_last;

    always_comb begin
        unique case (r_nbytes)
            NBYTES_W'(1): w_mask = 32'h0000_00ff;
            NBYTES_W'(2): w_mask = 32'h0000_ffff;
            default:      w_mask = 32'h00ff_ffff;
        endcase
    end

    // one 32x32 multiplier by the mix constant, shared by all multiply steps
    always_comb begin
        unique case (i_cmd.op)
            OP_KMUL1: w_mul_a = r_word;
            OP_KMUL2: w_mul_a = r_word ^ (r_word >> WORD_SHIFT);
            OP_HMUL:  w_mul_a = r_hash;
            OP_TAIL:  w_mul_a = r_hash ^ (r_word & w_mask);
            OP_FIN:   w_mul_a = r_hash ^ (r_hash >> FIN_SHIFT_A);
            default:  w_mul_a = '0;
        endcase
    end

    // only the low word of the product is kept
    assign w_prod = w_mul_a * MIX_MUL;

    // restoring division step, remainder stays below a nonzero divisor
    assign w_trial = {r_rem, r_quo[WORD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_tsize});
    always_comb begin
        logic [WORD_W:0] diff;
        diff  = w_trial - {1'b0, r_tsize};
        n_rem = w_ge ? diff[WORD_W-1:0] : w_trial[WORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else if (i_cmd.accept) begin
            if (i_first_word) begin
                r_hash <= r_seed ^ i_total_length;
            end
        end else if (i_cmd.op == OP_HMUL) begin
            r_hash <= w_prod ^ r_word;
        end else if (i_cmd.op == OP_TAIL) begin
            r_hash <= w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_word   <= i_key_word;
            r_nbytes <= i_bytes_valid;
            r_last   <= i_last_word;
        end else if (i_cmd.op == OP_KMUL1 || i_cmd.op == OP_KMUL2) begin
            r_word <= w_prod;
        end

        if (i_cmd.op == OP_FIN) begin
            r_fin <= w_prod ^ (w_prod >> FIN_SHIFT_B);
            r_quo <= w_prod ^ (w_prod >> FIN_SHIFT_B);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[WORD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end

        // zero table size leaves the full hash
        if (i_cmd.out_load) begin
            r_bucket <= (r_tsize == '0) ? r_fin : r_rem;
        end
    end

    assign o_bucket_index = r_bucket;

endmodule

// ----- rtl/mbh_ctrl.sv -----
// controller: sequences the multiply steps, final mix and modulo of each item
module mbh_ctrl
    import mbh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_KMUL1    = 4'd2;
    localparam logic [3:0] S_KMUL2    = 4'd3;
    localparam logic [3:0] S_HMUL     = 4'd4;
    localparam logic [3:0] S_TAIL     = 4'd5;
    localparam logic [3:0] S_FIN      = 4'd6;
    localparam logic [3:0] S_DIV      = 4'd7;
    localparam logic [3:0] S_PUT      = 4'd8;

    logic [3:0]           r_state;
    logic [3:0]           n_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_CNT_W-1:0] n_cnt;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 w_in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '{accept: 1'b0, op: OP_NONE, div_step: 1'b0, out_load: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = w_in_acc;
                if (w_in_acc) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_sts.full) begin
                    n_state = S_KMUL1;
                end else if (i_sts.tail) begin
                    n_state = S_TAIL;
                end else if (i_sts.last) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_KMUL1: begin
                o_cmd.op = OP_KMUL1;
                n_state  = S_KMUL2;
            end
            S_KMUL2: begin
                o_cmd.op = OP_KMUL2;
                n_state  = S_HMUL;
            end
            S_HMUL: begin
                o_cmd.op = OP_HMUL;
                n_state  = i_sts.last ? S_FIN : S_IDLE;
            end
            S_TAIL: begin
                o_cmd.op = OP_TAIL;
                n_state  = i_sts.last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_PUT;
                end else begin
                    n_cnt = r_cnt + DIV_CNT_W'(1);
                end
            end
            S_PUT: begin
                // wait while the previous result is still held
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_DISPATCH)
        else $error("accepted item not dispatched");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_DIV |-> r_cnt == '0)
        else $error("modulo step count active outside division");

    a_result_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid && r_state == S_IDLE)
        else $error("loaded result not presented");

endmodule

// ----- rtl/murmur2_bucket_hash.sv -----
// top level of the murmur2 bucket hash block
// Usage:
//   i_key takes a key as 32-bit words, first key byte in bits 7:0, with
//   bytes_valid, first_word and last_word marks; total_length is read on a
//   first word and seeds the hash with hash_seed xor total_length.
//   o_bucket gives one item per last word: the final hash modulo table_size
//   (the full hash when table_size is zero).
//   i_cfg writes hash_seed (index 0) and table_size (index 1), always ready;
//   the user must write it only while the block is idle; it is not enforced.
// Sequence:
//   one key word at a time; a full word passes dispatch and three dependent
//   multiplies on one shared 32x32 multiplier before the next ready, a tail
//   word dispatch and one multiply, an empty word dispatch only.
//   a last word adds the final mix, a bit-serial modulo and the load of the
//   output register, which waits while an earlier result is still held.
// Reset: synchronous, active low; hash_seed = 0, table_size = 1, running
//   hash = 0, no result pending.
// Stall: a result waits in the output register while the next words are
//   taken; a later result waits in the block until that register is free.
module murmur2_bucket_hash
    import mbh_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    mbh_key_if.sink       i_key,
    mbh_bucket_if.source  o_bucket,
    mbh_cfg_if.sink       i_cfg
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mbh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_key.valid),
        .o_in_ready  (i_key.ready),
        .o_out_valid (o_bucket.valid),
        .i_out_ready (o_bucket.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    mbh_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_key_word     (i_key.key_word),
        .i_bytes_valid  (i_key.bytes_valid),
        .i_first_word   (i_key.first_word),
        .i_last_word    (i_key.last_word),
        .i_total_length (i_key.total_length),
        .i_cfg_valid    (i_cfg.valid),
        .o_cfg_ready    (i_cfg.ready),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_bucket_index (o_bucket.bucket_index)
    );

endmodule

// ----- tb/tb_murmur2_bucket_hash.sv -----
`timescale 1ns / 1ps
// self-checking testbench for murmur2_bucket_hash: keyed word streams against a hash predictor
module tb_murmur2_bucket_hash;
    import mbh_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned HOLD_CYCLES = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mbh_key_if    key_ch ();
    mbh_bucket_if bkt_ch ();
    mbh_cfg_if    cfg_ch ();

    murmur2_bucket_hash DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (key_ch.sink),
        .o_bucket (bkt_ch.source),
        .i_cfg    (cfg_ch.sink)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [WORD_W-1:0] pred_seed;
    logic [WORD_W-1:0] pred_table;
    logic [WORD_W-1:0] pred_hash;
    logic [WORD_W-1:0] expected_buckets[$];

    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned buckets_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned cycle_count = 0;

    // sender pacing
    int unsigned burst_left = 0;
    bit          no_gaps = 1'b0;
    bit          key_live = 1'b0;

    // receiver stall pattern
    logic        holding = 1'b0;
    logic [31:0] rx_mask = '1;
    logic [5:0]  rx_phase = '0;
    event        hold_kick;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void predict_bucket(input logic [WORD_W-1:0] word,
                                           input logic [NBYTES_W-1:0] nbytes,
                                           input logic first, input logic last,
                                           input logic [WORD_W-1:0] total,
                                           output logic emit,
                                           output logic [WORD_W-1:0] bucket);
        logic [WORD_W-1:0] k;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] h;
        if (first) begin
            pred_hash = pred_seed ^ total;
        end
        if (nbytes >= 3'd4) begin
            k = word * MIX_MUL;
            k = k ^ (k >> WORD_SHIFT);
            k = k * MIX_MUL;
            pred_hash = (pred_hash * MIX_MUL) ^ k;
        end else if (nbytes != 3'd0) begin
            case (nbytes)
                3'd1: mask = 32'h0000_00ff;
                3'd2: mask = 32'h0000_ffff;
                default: mask = 32'h00ff_ffff;
            endcase
            pred_hash = (pred_hash ^ (word & mask)) * MIX_MUL;
        end
        emit = last;
        h = pred_hash ^ (pred_hash >> FIN_SHIFT_A);
        h = h * MIX_MUL;
        h = h ^ (h >> FIN_SHIFT_B);
        if (pred_table != '0) begin
            h = h % pred_table;
        end
        bucket = h;
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] word, input logic [NBYTES_W-1:0] nbytes,
                             input logic first, input logic last,
                             input logic [WORD_W-1:0] total);
        logic              emit;
        logic [WORD_W-1:0] bucket;
        key_ch.valid        <= 1'b1;
        key_ch.key_word     <= word;
        key_ch.bytes_valid  <= nbytes;
        key_ch.first_word   <= first;
        key_ch.last_word    <= last;
        key_ch.total_length <= total;
        key_live = 1'b1;
        @(posedge i_clk);
        while (!key_ch.ready) @(posedge i_clk);
        predict_bucket(word, nbytes, first, last, total, emit, bucket);
        if (emit) begin
            expected_buckets.push_back(bucket);
        end
        words_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0 && !no_gaps) begin
            key_ch.valid <= 1'b0;
            key_live = 1'b0;
            // mostly short gaps, now and then long enough to span the modulo
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(7, 45)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
        end
    endtask

    task automatic wait_idle();
        if (key_live) begin
            key_ch.valid <= 1'b0;
            key_live = 1'b0;
        end
        while (expected_buckets.size() != 0) @(posedge i_clk);
        // words that give no item may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_HASH_SEED:  pred_seed = data;
            REG_TABLE_SIZE: pred_table = data;
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [WORD_W-1:0] seed, input logic [WORD_W-1:0] tsize);
        wait_idle();
        write_reg(REG_HASH_SEED, seed);
        write_reg(REG_TABLE_SIZE, tsize);
    endtask

    task automatic send_random_key();
        int unsigned len;
        int unsigned nwords;
        int unsigned nb;
        if ($urandom_range(0, 99) < 85) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            nwords = (len + 3) / 4;
            for (int unsigned w = 0; w < nwords; w++) begin
                nb = (w == nwords - 1 && len % 4 != 0) ? len % 4 : 4;
                send_word($urandom, nb[NBYTES_W-1:0], w == 0, w == nwords - 1, len);
            end
        end else begin
            // noise: any width, any markers, any length
            repeat ($urandom_range(1, 4)) begin
                send_word($urandom, NBYTES_W'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
            end
        end
    endtask

    task automatic test_reset_defaults();
        // seed 0 and one bucket until written
        send_word(32'hdead_beef, 3'd4, 1'b1, 1'b1, 32'd4);
        send_word(32'h0000_0041, 3'd1, 1'b1, 1'b1, 32'd1);
    endtask

    task automatic test_special_words();
        set_config(32'hffff_ffff, 32'h0000_0000);
        send_word(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 32'd4);
        send_word(32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'd1);
        // unused high bytes carry junk
        send_word(32'hffff_ff80, 3'd1, 1'b1, 1'b1, 32'd1);
        send_word(32'ha5a5_8001, 3'd2, 1'b1, 1'b1, 32'd2);
        send_word(32'h12ff_ffff, 3'd3, 1'b1, 1'b1, 32'd3);
        send_word(32'h1234_5678, 3'd0, 1'b1, 1'b1, 32'hffff_ffff);
        send_word(32'h8765_4321, 3'd5, 1'b1, 1'b1, 32'd5);
        send_word(32'hcafe_f00d, 3'd7, 1'b1, 1'b1, 32'd7);
        // partial word in the middle of a key
        send_word(32'h0102_0304, 3'd6, 1'b1, 1'b0, 32'd9);
        send_word(32'hffff_1122, 3'd2, 1'b0, 1'b0, 32'd0);
        send_word(32'h5566_7788, 3'd4, 1'b0, 1'b1, 32'd0);
        // continuing without a first word picks up the pre-mix hash
        send_word(32'h0bad_c0de, 3'd4, 1'b0, 1'b1, 32'hffff_ffff);
        send_word(32'h7777_7777, 3'd0, 1'b0, 1'b1, 32'd0);
        send_word(32'h1111_2222, 3'd4, 1'b0, 1'b0, 32'd0);
        send_word(32'h3333_4444, 3'd3, 1'b0, 1'b1, 32'd0);
        // a second first word restarts the key
        send_word(32'haaaa_aaaa, 3'd4, 1'b1, 1'b0, 32'd8);
        send_word(32'h5555_5555, 3'd4, 1'b1, 1'b0, 32'h8000_0000);
        send_word(32'h0f0f_0f0f, 3'd4, 1'b0, 1'b1, 32'd0);
        send_word(32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'h0000_0000);
    endtask

    task automatic test_random_keys(input logic [WORD_W-1:0] seed,
                                    input logic [WORD_W-1:0] tsize,
                                    input int unsigned n_words);
        int unsigned stop_at;
        set_config(seed, tsize);
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) send_random_key();
    endtask

    task automatic test_output_backpressure();
        set_config($urandom, $urandom_range(1, 1000));
        -> hold_kick;
        no_gaps = 1'b1;
        repeat (24) send_word($urandom, 3'd4, 1'b1, 1'b1, 32'd4);
        no_gaps = 1'b0;
        burst_left = 0;
    endtask

    // result checker and stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && bkt_ch.valid && bkt_ch.ready) begin
            if (expected_buckets.size() == 0) begin
                report_mismatch($sformatf("bucket %08h with nothing expected",
                                          bkt_ch.bucket_index));
            end else begin
                if (bkt_ch.bucket_index !== expected_buckets[0]) begin
                    report_mismatch($sformatf("bucket_index got %08h expected %08h",
                                              bkt_ch.bucket_index, expected_buckets[0]));
                end
                void'(expected_buckets.pop_front());
                buckets_checked++;
            end
        end
        rx_phase <= rx_phase + 6'd1;
        if (rx_phase == 6'd63) begin
            rx_mask <= ($urandom_range(0, 2) == 0) ? 32'hffff_ffff : $urandom;
        end
        bkt_ch.ready <= !holding && rx_mask[rx_phase[4:0]];
    end

    // long receiver hold-off
    always begin
        @(hold_kick);
        @(posedge i_clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items outstanding",
                     cycle_count, expected_buckets.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        key_ch.valid        <= 1'b0;
        key_ch.key_word     <= '0;
        key_ch.bytes_valid  <= '0;
        key_ch.first_word   <= 1'b0;
        key_ch.last_word    <= 1'b0;
        key_ch.total_length <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        pred_seed  = '0;
        pred_table = 32'd1;
        pred_hash  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_special_words();
        test_random_keys(32'hffff_ffff, 32'hffff_ffff, 110);
        test_random_keys(32'h0000_0000, 32'h0000_0001, 60);
        test_output_backpressure();
        test_random_keys($urandom, $urandom_range(2, 17), 110);
        test_random_keys($urandom, 32'h0001_0000, 100);
        test_random_keys($urandom, $urandom, 110);
        test_random_keys($urandom, 32'h0000_0000, 60);

        wait_idle();
        $display("sent %0d key words over %0d register writes, checked %0d buckets",
                 words_sent, reg_writes, buckets_checked);
        $display("covered tails, odd widths, marker misuse, table extremes and a long output stall");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
